// ===== sv/assert_macros.svh =====
// assertion macros shared by the allocator rtl
// needs a clk and an active-low rst_n in the scope of each use

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define FBPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define FBPA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fbpa_pkg.sv =====
// shared constants, types and helper functions of the block pool allocator
// no dependencies; imported by every allocator module

package fbpa_pkg;

    localparam int SMALL_COUNT  = 8;
    localparam int MIDDLE_COUNT = 8;
    localparam int LARGE_COUNT  = 4;
    localparam int HEADER_BYTES = 8;

    localparam int CLASS_COUNT  = 3;
    localparam int SMALL_BYTES  = 16;
    localparam int MIDDLE_BYTES = 32;
    localparam int LARGE_BYTES  = 64;
    localparam int SMALL_SHIFT  = $clog2(SMALL_BYTES);
    localparam int MIDDLE_SHIFT = $clog2(MIDDLE_BYTES);
    localparam int LARGE_SHIFT  = $clog2(LARGE_BYTES);

    localparam int ADDR_W = 32;
    localparam int SIZE_W = 16;

    localparam int MAX_COUNT = (SMALL_COUNT > MIDDLE_COUNT)
        ? ((SMALL_COUNT > LARGE_COUNT) ? SMALL_COUNT : LARGE_COUNT)
        : ((MIDDLE_COUNT > LARGE_COUNT) ? MIDDLE_COUNT : LARGE_COUNT);
    localparam int BLK_W = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
    localparam int CNT_W = $clog2(MAX_COUNT + 1);

    // pool layout, byte offsets from the area base
    localparam int MIDDLE_START = SMALL_BYTES * SMALL_COUNT;
    localparam int LARGE_START  = MIDDLE_START + MIDDLE_BYTES * MIDDLE_COUNT;
    localparam int AREA_BYTES   = LARGE_START + LARGE_BYTES * LARGE_COUNT;
    localparam int AREA_W       = $clog2(AREA_BYTES);
    localparam int OFF_W        = $clog2(AREA_BYTES + HEADER_BYTES);

    typedef logic [1:0]       cls_t;
    typedef logic [BLK_W-1:0] blk_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam cls_t CLS_SMALL  = 2'd0;
    localparam cls_t CLS_MIDDLE = 2'd1;
    localparam cls_t CLS_LARGE  = 2'd2;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_FIT,
        ST_EMPTY,
        ST_BAD_ADDR
    } status_t;

    typedef struct packed {
        logic              command;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] release_address;
    } item_t;

    // decoded view of one item
    typedef struct packed {
        logic alloc_fit;
        cls_t alloc_cls;
        logic rel_hit;
        logic rel_aligned;
        cls_t rel_cls;
        blk_t rel_blk;
    } dec_t;

    // free stack state seen for the selected class
    typedef struct packed {
        logic empty;
        logic full;
        blk_t top_blk;
        logic blk_in_use;
    } view_t;

    typedef struct packed {
        logic pop;
        logic push;
    } stack_ctrl_t;

    function automatic cnt_t pool_blocks(cls_t cls);
        case (cls)
            CLS_SMALL:  return cnt_t'(SMALL_COUNT);
            CLS_MIDDLE: return cnt_t'(MIDDLE_COUNT);
            CLS_LARGE:  return cnt_t'(LARGE_COUNT);
            default:    return '0;
        endcase
    endfunction

    // payload start of a block, relative to the area base
    function automatic logic [OFF_W-1:0] payload_offset(cls_t cls, blk_t blk);
        logic [OFF_W-1:0] blk_w;
        blk_w = OFF_W'(blk);
        case (cls)
            CLS_SMALL:  return OFF_W'(HEADER_BYTES) + (blk_w << SMALL_SHIFT);
            CLS_MIDDLE: return OFF_W'(MIDDLE_START + HEADER_BYTES) + (blk_w << MIDDLE_SHIFT);
            CLS_LARGE:  return OFF_W'(LARGE_START + HEADER_BYTES) + (blk_w << LARGE_SHIFT);
            default:    return '0;
        endcase
    endfunction

endpackage

// ===== sv/fixed_block_pool_allocator_unit.sv =====
// top level of the three-class fixed block pool allocator
// depends on fbpa_pkg, fbpa_decode, fbpa_free_stacks and assert_macros.svh

// Allocator for three pools of 16, 32 and 64-byte blocks laid out back to back
// from cfg_data (area base); each block starts with a header and allocates hand
// out the payload address just past it. One item is accepted per clock while
// m_tready keeps the result register draining: it lands in an input register,
// the class decode, stack pop or push and address add run from there, and the
// result is registered in the result register that drives m_tdata. That rate
// is set by the free stack update, which finishes between the input register
// and the result register. The input stage keeps taking items while a result
// waits on m_tready, until both registers are full.
// Write the area base only while no item is in flight.

`include "assert_macros.svh"

module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // item in
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // request_size[15:0], release_address[47:16]
    input  logic [0:0]        s_tuser,   // command[0]
    // result out
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // status[1:0], block_address[33:2],
                                         // pool_index[35:34], zero[39:36]
    // area base register
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data
);

    localparam int M_USED = 2 + ADDR_W + 2;
    localparam int M_PAD  = 40 - M_USED;

    logic [ADDR_W-1:0] area_base_reg;

    // input register
    logic  in_valid_reg;
    item_t item_reg;
    item_t item_next;

    // result register
    logic              out_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    cls_t              pool_reg;
    cls_t              pool_next;

    logic        advance;
    dec_t        dec;
    view_t       view;
    stack_ctrl_t ctrl;
    cls_t        cls;

    // the held item moves on when the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign item_next.command         = s_tuser[0];
    assign item_next.request_size    = s_tdata[SIZE_W-1:0];
    assign item_next.release_address = s_tdata[SIZE_W+ADDR_W-1:SIZE_W];

    fbpa_decode u_decode (
        .item      (item_reg),
        .area_base (area_base_reg),
        .dec       (dec)
    );

    assign cls = (item_reg.command == CMD_ALLOC) ? dec.alloc_cls : dec.rel_cls;

    fbpa_free_stacks u_stacks (
        .clk   (clk),
        .rst_n (rst_n),
        .cls   (cls),
        .blk   (dec.rel_blk),
        .ctrl  (ctrl),
        .view  (view)
    );

    always_comb
    begin
        ctrl        = '0;
        status_next = ST_OK;
        addr_next   = '0;
        pool_next   = CLS_SMALL;
        if (item_reg.command == CMD_ALLOC)
        begin
            if (!dec.alloc_fit)
            begin
                status_next = ST_NO_FIT;
            end
            else if (view.empty)
            begin
                // no fall-through to a larger class
                status_next = ST_EMPTY;
                pool_next   = cls;
            end
            else
            begin
                pool_next = cls;
                addr_next = area_base_reg + ADDR_W'(payload_offset(cls, view.top_blk));
                ctrl.pop  = advance;
            end
        end
        else
        begin
            if (!(dec.rel_hit && dec.rel_aligned))
            begin
                // not a payload start in any pool
                status_next = ST_BAD_ADDR;
            end
            else if (!view.blk_in_use || view.full)
            begin
                // double release
                status_next = ST_BAD_ADDR;
                pool_next   = cls;
            end
            else
            begin
                pool_next = cls;
                ctrl.push = advance;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_base_reg <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                area_base_reg <= cfg_data;
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= item_next;
        if (advance)
        begin
            status_reg <= status_next;
            addr_reg   <= addr_next;
            pool_reg   <= pool_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD{1'b0}}, pool_reg, addr_reg, status_reg};

    `FBPA_ASSERT_NEXT(a_item_reaches_result, advance, out_valid_reg, "advanced item has no result")
    `FBPA_ASSERT_IMPL(a_addr_only_on_ok, out_valid_reg && status_reg != ST_OK, addr_reg == '0, "address on a failed item")
    `FBPA_ASSERT_IMPL(a_no_fit_small, out_valid_reg && status_reg == ST_NO_FIT, pool_reg == CLS_SMALL, "no-fit result names a class")

endmodule

// ===== sv/fbpa_decode.sv =====
// size class choice for allocates and address decode for releases
// depends on fbpa_pkg

module fbpa_decode
    import fbpa_pkg::*;
(
    input  item_t             item,
    input  logic [ADDR_W-1:0] area_base,
    output dec_t              dec
);

    logic [ADDR_W-1:0] off;
    logic [AREA_W-1:0] off_n;
    logic [AREA_W-1:0] rel_off;

    always_comb
    begin
        dec     = '0;
        rel_off = '0;

        // first class whose payload holds the request
        if (item.request_size <= SIZE_W'(SMALL_BYTES - HEADER_BYTES))
        begin
            dec.alloc_fit = 1'b1;
            dec.alloc_cls = CLS_SMALL;
        end
        else if (item.request_size <= SIZE_W'(MIDDLE_BYTES - HEADER_BYTES))
        begin
            dec.alloc_fit = 1'b1;
            dec.alloc_cls = CLS_MIDDLE;
        end
        else if (item.request_size <= SIZE_W'(LARGE_BYTES - HEADER_BYTES))
        begin
            dec.alloc_fit = 1'b1;
            dec.alloc_cls = CLS_LARGE;
        end

        // area-relative offset of the block start, wraps at 32 bits
        off         = item.release_address - area_base - ADDR_W'(HEADER_BYTES);
        off_n       = off[AREA_W-1:0];
        dec.rel_hit = off < ADDR_W'(AREA_BYTES);

        if (off_n < AREA_W'(MIDDLE_START))
        begin
            rel_off         = off_n;
            dec.rel_cls     = CLS_SMALL;
            dec.rel_aligned = rel_off[SMALL_SHIFT-1:0] == '0;
            dec.rel_blk     = BLK_W'(rel_off >> SMALL_SHIFT);
        end
        else if (off_n < AREA_W'(LARGE_START))
        begin
            rel_off         = off_n - AREA_W'(MIDDLE_START);
            dec.rel_cls     = CLS_MIDDLE;
            dec.rel_aligned = rel_off[MIDDLE_SHIFT-1:0] == '0;
            dec.rel_blk     = BLK_W'(rel_off >> MIDDLE_SHIFT);
        end
        else
        begin
            rel_off         = off_n - AREA_W'(LARGE_START);
            dec.rel_cls     = CLS_LARGE;
            dec.rel_aligned = rel_off[LARGE_SHIFT-1:0] == '0;
            dec.rel_blk     = BLK_W'(rel_off >> LARGE_SHIFT);
        end
    end

endmodule

// ===== sv/fbpa_free_stacks.sv =====
// lifo free stacks, fill counts and in-use flags of the three pools
// depends on fbpa_pkg and assert_macros.svh

`include "assert_macros.svh"

module fbpa_free_stacks
    import fbpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cls_t        cls,
    input  blk_t        blk,
    input  stack_ctrl_t ctrl,
    output view_t       view
);

    blk_t                 stack_reg  [CLASS_COUNT][MAX_COUNT];
    cnt_t                 count_reg  [CLASS_COUNT];
    logic [MAX_COUNT-1:0] in_use_reg [CLASS_COUNT];

    cnt_t cnt;
    cnt_t top_idx;

    always_comb
    begin
        cnt             = count_reg[cls];
        top_idx         = cnt - cnt_t'(1);
        view.empty      = cnt == '0;
        view.full       = cnt >= pool_blocks(cls);
        view.top_blk    = stack_reg[cls][top_idx[BLK_W-1:0]];
        view.blk_in_use = in_use_reg[cls][blk];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // every block free, block 0 on top
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                for (int k = 0; k < MAX_COUNT; k++)
                begin
                    if (k < int'(pool_blocks(cls_t'(c))))
                        stack_reg[c][k] <= BLK_W'(int'(pool_blocks(cls_t'(c))) - 1 - k);
                    else
                        stack_reg[c][k] <= '0;
                end
                count_reg[c]  <= pool_blocks(cls_t'(c));
                in_use_reg[c] <= '0;
            end
        end
        else
        begin
            if (ctrl.pop)
            begin
                count_reg[cls]                 <= top_idx;
                in_use_reg[cls][view.top_blk]  <= 1'b1;
            end
            if (ctrl.push)
            begin
                stack_reg[cls][cnt[BLK_W-1:0]] <= blk;
                count_reg[cls]                 <= cnt + cnt_t'(1);
                in_use_reg[cls][blk]           <= 1'b0;
            end
        end
    end

    `FBPA_ASSERT(a_small_balance, $countones(in_use_reg[CLS_SMALL]) + int'(count_reg[CLS_SMALL]) == SMALL_COUNT, "small pool blocks lost or duplicated")
    `FBPA_ASSERT(a_large_balance, $countones(in_use_reg[CLS_LARGE]) + int'(count_reg[CLS_LARGE]) == LARGE_COUNT, "large pool blocks lost or duplicated")
    `FBPA_ASSERT_IMPL(a_pop_free_block, ctrl.pop, !in_use_reg[cls][view.top_blk], "popped block is marked in use")

endmodule

// ===== tb/fbpa_alloc_checker.sv =====
// watches the item, result and area base channels of the block pool allocator,
// predicts every result and compares it field by field; depends on fbpa_pkg

module fbpa_alloc_checker
    import fbpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [47:0]       s_tdata,
    input  logic [0:0]        s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [39:0]       m_tdata,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data,
    output int                mismatch_count,
    output int                grants_owed
);

    typedef struct {
        status_t           status;
        logic [ADDR_W-1:0] address;
        cls_t              pool;
    } grant_t;

    localparam int unsigned CLASS_BYTES  [CLASS_COUNT] = '{SMALL_BYTES, MIDDLE_BYTES, LARGE_BYTES};
    localparam int unsigned CLASS_BLOCKS [CLASS_COUNT] = '{SMALL_COUNT, MIDDLE_COUNT, LARGE_COUNT};
    localparam int unsigned CLASS_START  [CLASS_COUNT] = '{0, MIDDLE_START, LARGE_START};

    logic [ADDR_W-1:0] area_base;
    int                free_stack [CLASS_COUNT][MAX_COUNT];
    int                free_depth [CLASS_COUNT];
    bit                in_use     [CLASS_COUNT][MAX_COUNT];
    grant_t            expected_grants [$];

    grant_t            want;
    logic [1:0]        got_status;
    logic [ADDR_W-1:0] got_address;
    logic [1:0]        got_pool;

    function automatic void clear_pools();
        area_base = '0;
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            for (int k = 0; k < MAX_COUNT; k++)
            begin
                free_stack[c][k] = (k < CLASS_BLOCKS[c]) ? CLASS_BLOCKS[c] - 1 - k : 0;
                in_use[c][k]     = 1'b0;
            end
            free_depth[c] = CLASS_BLOCKS[c];
        end
    endfunction

    // applies one item to the pool copy and returns the result it causes
    function automatic grant_t predict_grant(logic cmd, logic [SIZE_W-1:0] size,
                                             logic [ADDR_W-1:0] addr);
        grant_t            g;
        bit                decided;
        int                blk;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] rel;
        g.address = '0;
        g.pool    = CLS_SMALL;
        decided   = 1'b0;
        if (cmd == CMD_ALLOC)
        begin
            g.status = ST_NO_FIT;
            // first class whose payload holds the request, no fall-through
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                if (!decided && size <= CLASS_BYTES[c] - HEADER_BYTES)
                begin
                    decided = 1'b1;
                    g.pool  = cls_t'(c);
                    if (free_depth[c] == 0)
                        g.status = ST_EMPTY;
                    else
                    begin
                        free_depth[c]--;
                        blk = free_stack[c][free_depth[c]] % CLASS_BLOCKS[c];
                        in_use[c][blk] = 1'b1;
                        g.status  = ST_OK;
                        g.address = area_base + CLASS_START[c] + blk * CLASS_BYTES[c]
                                    + HEADER_BYTES;
                    end
                end
            end
        end
        else
        begin
            g.status = ST_BAD_ADDR;
            off = addr - HEADER_BYTES - area_base;
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                if (!decided && off >= CLASS_START[c]
                    && off - CLASS_START[c] < CLASS_BYTES[c] * CLASS_BLOCKS[c])
                begin
                    decided = 1'b1;
                    rel = off - CLASS_START[c];
                    // inside a pool but not a payload start: class stays small
                    if (rel % CLASS_BYTES[c] == 0)
                    begin
                        blk    = rel / CLASS_BYTES[c];
                        g.pool = cls_t'(c);
                        if (in_use[c][blk] && free_depth[c] < CLASS_BLOCKS[c])
                        begin
                            in_use[c][blk] = 1'b0;
                            free_stack[c][free_depth[c]] = blk;
                            free_depth[c]++;
                            g.status = ST_OK;
                        end
                    end
                end
            end
        end
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_pools();
            expected_grants.delete();
            mismatch_count = 0;
            grants_owed    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                area_base = cfg_data;

            // result first: it always belongs to an item older than this edge
            if (m_tvalid && m_tready)
            begin
                got_status  = m_tdata[1:0];
                got_address = m_tdata[33:2];
                got_pool    = m_tdata[35:34];
                if (expected_grants.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d address %h pool %0d",
                             $time, got_status, got_address, got_pool);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (got_status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got_status);
                        mismatch_count++;
                    end
                    if (got_address !== want.address)
                    begin
                        $display("%0t: block_address expected %h actual %h",
                                 $time, want.address, got_address);
                        mismatch_count++;
                    end
                    if (got_pool !== want.pool)
                    begin
                        $display("%0t: pool_index expected %0d actual %0d",
                                 $time, want.pool, got_pool);
                        mismatch_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
                expected_grants.push_back(predict_grant(s_tuser[0], s_tdata[15:0],
                                                        s_tdata[47:16]));

            grants_owed = expected_grants.size();
        end
    end

endmodule

// ===== tb/tb_fixed_block_pool_allocator_unit.sv =====
// stimulus and verdict for the three-class block pool allocator
// depends on fbpa_pkg, fixed_block_pool_allocator_unit and fbpa_alloc_checker

module tb_fixed_block_pool_allocator_unit;
    import fbpa_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASE_ITEMS = 140;
    localparam int HOLD_CYCLES = 80;
    localparam int IDLE_PCT    = 37;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [47:0]       s_tdata;    // request_size[15:0], release_address[47:16]
    logic [0:0]        s_tuser;    // command[0]
    logic              m_tvalid;
    logic              m_tready;
    logic [39:0]       m_tdata;    // status[1:0], block_address[33:2], pool_index[35:34]
    logic              cfg_valid;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data;

    int                mismatch_count;
    int                grants_owed;
    int                cycle_count;

    // steady and hold_asks are shared between the stimulus and the receiver
    bit                steady;        // no idling on either side
    int                hold_asks;     // bumped to request one long receiver hold
    logic [ADDR_W-1:0] current_base;  // area base last written

    fixed_block_pool_allocator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    fbpa_alloc_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .grants_owed    (grants_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog on the whole run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver: random backpressure, a calm mode, and long holds on request
    initial
    begin
        int holds_done;
        int hold_left;
        holds_done = 0;
        hold_left  = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != holds_done)
            begin
                holds_done = hold_asks;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // payload address of a block under the current area base
    function automatic logic [ADDR_W-1:0] payload_of(int c, int blk);
        case (c)
            CLS_SMALL:  return current_base + blk * SMALL_BYTES + HEADER_BYTES;
            CLS_MIDDLE: return current_base + MIDDLE_START + blk * MIDDLE_BYTES + HEADER_BYTES;
            default:    return current_base + LARGE_START + blk * LARGE_BYTES + HEADER_BYTES;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    // valid stays high on return so back-to-back items need no extra step
    task automatic offer_item(input logic cmd, input logic [SIZE_W-1:0] size,
                              input logic [ADDR_W-1:0] addr);
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {addr, size};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (grants_owed != 0)
            @(negedge clk);
        // let the two-stage pipe settle before touching the base
        repeat (4) @(negedge clk);
    endtask

    task automatic write_area_base(input logic [ADDR_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid    <= 1'b0;
        current_base = value;
    endtask

    // mostly well-formed traffic: small sizes and real payload addresses
    task automatic random_item();
        int                pick;
        int                c;
        int                blk;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(99);
        size = SIZE_W'($urandom);
        addr = $urandom;
        if (pick < 48)
        begin
            if ($urandom_range(99) < 85)
                size = SIZE_W'($urandom_range(60));
            offer_item(CMD_ALLOC, size, addr);
        end
        else
        begin
            c = $urandom_range(CLASS_COUNT - 1);
            case (c)
                CLS_SMALL:  blk = $urandom_range(SMALL_COUNT - 1);
                CLS_MIDDLE: blk = $urandom_range(MIDDLE_COUNT - 1);
                default:    blk = $urandom_range(LARGE_COUNT - 1);
            endcase
            pick = $urandom_range(99);
            if (pick < 75)
                addr = payload_of(c, blk);
            else if (pick < 90)
                addr = payload_of(c, blk) + $urandom_range(1, SMALL_BYTES - 1);
            offer_item(CMD_RELEASE, size, addr);
        end
    endtask

    initial
    begin
        logic [ADDR_W-1:0] phase_base [5];
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        steady       = 1'b0;
        hold_asks    = 0;
        current_base = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part at base zero
        write_area_base('0);
        offer_item(CMD_ALLOC, 16'd0, '0);              // zero bytes lands in small
        offer_item(CMD_ALLOC, 16'd8, '0);              // largest small payload
        offer_item(CMD_ALLOC, 16'd9, '0);              // smallest middle
        offer_item(CMD_ALLOC, 16'd24, '0);             // largest middle
        offer_item(CMD_ALLOC, 16'd25, '0);             // smallest large
        offer_item(CMD_ALLOC, 16'd56, '0);             // largest large
        offer_item(CMD_ALLOC, 16'd57, '0);             // no class fits
        offer_item(CMD_ALLOC, 16'hFFFF, 32'hFFFF_FFFF);
        for (int k = 1; k <= 6; k++)
            offer_item(CMD_ALLOC, SIZE_W'(k), '0);     // drain the small pool
        offer_item(CMD_ALLOC, 16'd3, '0);              // small pool empty, no fall-through
        offer_item(CMD_RELEASE, '0, payload_of(CLS_SMALL, 0) + 4);   // not a payload start
        offer_item(CMD_RELEASE, 16'hFFFF, 32'hFFFF_FFFF);            // outside every pool
        offer_item(CMD_RELEASE, '0, payload_of(CLS_LARGE, LARGE_COUNT - 1)); // never allocated
        offer_item(CMD_RELEASE, '0, payload_of(CLS_SMALL, 0));       // good release
        offer_item(CMD_RELEASE, '0, payload_of(CLS_SMALL, 0));       // double release
        offer_item(CMD_RELEASE, '0, AREA_BYTES + HEADER_BYTES);      // just past the area
        offer_item(CMD_ALLOC, '0, '0);                 // lifo hands block 0 back
        offer_item(CMD_RELEASE, '0, payload_of(CLS_MIDDLE, 1));

        // random phases over several bases, extremes included
        phase_base[0] = '0;
        phase_base[1] = 32'hFFFF_FFFF;
        phase_base[2] = 32'hFFFF_FF00;   // pools straddle the address wrap
        phase_base[3] = $urandom;
        phase_base[4] = 32'h8000_0004;
        for (int p = 0; p < 5; p++)
        begin
            if (p != 0)
                write_area_base(phase_base[p]);
            steady = (p == 2);
            if (p == 3)
                hold_asks++;             // receiver stalls while items keep coming
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
        end
        steady = 1'b0;

        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
